>>> rtl/ttseq_pkg.sv
// Shared types, constants and pitch table of the tone tune sequencer.
`default_nettype none

package ttseq_pkg;

    localparam int CMD_W    = 3;
    localparam int PIDX_W   = 7;
    localparam int FREQ_W   = 15;
    localparam int LEN_W    = 16;
    localparam int CLK_W    = 24;
    localparam int PERIOD_W = 16;

    localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TONE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    localparam logic [CLK_W-1:0] CLOCK_RESET = 24'd2000000;

    localparam int PITCH_COUNT = 72;
    localparam logic [11:0] PITCH_HZ [PITCH_COUNT] = '{
        12'd55,   12'd58,   12'd62,   12'd65,   12'd69,   12'd73,
        12'd78,   12'd82,   12'd87,   12'd92,   12'd98,   12'd104,
        12'd110,  12'd117,  12'd123,  12'd131,  12'd139,  12'd147,
        12'd156,  12'd165,  12'd175,  12'd185,  12'd196,  12'd208,
        12'd220,  12'd233,  12'd246,  12'd261,  12'd277,  12'd293,
        12'd311,  12'd330,  12'd349,  12'd370,  12'd392,  12'd415,
        12'd440,  12'd466,  12'd493,  12'd523,  12'd554,  12'd587,
        12'd622,  12'd659,  12'd698,  12'd740,  12'd784,  12'd830,
        12'd880,  12'd932,  12'd988,  12'd1047, 12'd1109, 12'd1175,
        12'd1245, 12'd1319, 12'd1397, 12'd1480, 12'd1568, 12'd1661,
        12'd1760, 12'd1865, 12'd1976, 12'd2093, 12'd2217, 12'd2349,
        12'd2489, 12'd2637, 12'd2794, 12'd2960, 12'd3136, 12'd3322
    };

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [LEN_W-1:0]  len;
    } t_note;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } t_state;

    function automatic logic [FREQ_W-1:0] pitch_freq(input logic [PIDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        f = '0;
        if (idx != '0 && idx < PIDX_W'(PITCH_COUNT)) begin
            f = FREQ_W'(PITCH_HZ[idx]);
        end
        return f;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ttseq_if.sv
// Channel interfaces: command, result and timer clock configuration.
`default_nettype none

interface ttseq_cmd_if import ttseq_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PIDX_W-1:0]   pitch_index;
    logic [FREQ_W-1:0]   frequency;
    logic [LEN_W-1:0]    note_length;

    modport source (output valid, command, pitch_index, frequency, note_length,
                    input ready);
    modport sink   (input valid, command, pitch_index, frequency, note_length,
                    output ready);
endinterface

interface ttseq_res_if import ttseq_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                tone_on;
    logic [PERIOD_W-1:0] tone_period;
    logic                playing;
    logic                dropped;

    modport source (output valid, tone_on, tone_period, playing, dropped,
                    input ready);
    modport sink   (input valid, tone_on, tone_period, playing, dropped,
                    output ready);
endinterface

interface ttseq_cfg_if import ttseq_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [CLK_W-1:0]    timer_clock;

    modport source (output valid, timer_clock, input ready);
    modport sink   (input valid, timer_clock, output ready);
endinterface

`default_nettype wire

>>> rtl/ttseq_store.sv
// Note store: single-port write, registered read memory of notes.
`default_nettype none

module ttseq_store import ttseq_pkg::*; #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_note             i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_note             o_rdata
);

    t_note mem [DEPTH];
    t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/ttseq_div.sv
// Restoring divider, one quotient bit per cycle, saturated period output.
`default_nettype none

module ttseq_div import ttseq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CLK_W-1:0]    i_dividend,
    input  logic [FREQ_W-1:0]   i_divisor,
    output t_div_stat           o_stat,
    output logic [PERIOD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(CLK_W);

    logic [FREQ_W-1:0] r_rem;
    logic [CLK_W-1:0]  r_quo;
    logic [FREQ_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [FREQ_W:0]   rem_sh;
    logic [FREQ_W:0]   diff;
    logic              take;

    assign rem_sh = {r_rem, r_quo[CLK_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign take   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CLK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
            r_quo <= {r_quo[CLK_W-2:0], take};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = (|r_quo[CLK_W-1:PERIOD_W]) ? '1 : r_quo[PERIOD_W-1:0];

endmodule

`default_nettype wire

>>> rtl/tone_tune_sequencer.sv
// Tone tune sequencer top level: command sequencer, note store and divider.
//
// Channels: i_cmd takes one command per transfer (begin load, append
// indexed note, start play, single tone, tick); o_res returns exactly one
// status item per command; i_cfg writes the timer clock and is always ready.
// Begin load, append, start play, single tone and ticks past the end of
// the tune give their result in the cycle after the command transfer.
// A tick inside the tune reads the note store in ST_EVAL; on a note's first
// tick with a non-zero frequency the restoring divider then runs in ST_DIV
// before the result, one quotient bit per cycle; other ticks go to ST_OUT.
// One command is in flight at a time: i_cmd.ready is low from the command
// transfer until its result has been taken, so a new command is taken only
// after the result of the last one has gone.
// The result is held on o_res while the receiver stalls; nothing is lost.
// Reset clears pointers, tick count and tone state and loads the timer
// clock with 2000000; note store contents are undefined until written.
`default_nettype none

module tone_tune_sequencer import ttseq_pkg::*; #(
    parameter int NOTE_DEPTH = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttseq_cmd_if.sink   i_cmd,
    ttseq_res_if.source o_res,
    ttseq_cfg_if.sink   i_cfg
);

    localparam int PTR_W  = $clog2(NOTE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NOTE_DEPTH);

    t_state              r_state, n_state;
    logic [CLK_W-1:0]    r_timer_clock;
    logic [PTR_W-1:0]    r_load_ptr, n_load_ptr;
    logic [PTR_W-1:0]    r_tune_len, n_tune_len;
    logic [PTR_W-1:0]    r_play_idx, n_play_idx;
    logic [LEN_W-1:0]    r_tick_cnt, n_tick_cnt;
    logic                r_tone_running, n_tone_running;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic                r_dropped, n_dropped;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_note               mem_wdata;
    logic                mem_re;
    t_note               mem_rdata;
    logic                div_start;
    t_div_stat           div_stat;
    logic [PERIOD_W-1:0] div_quot;
    logic [LEN_W:0]      tick_sum;
    logic                cmd_xfer;
    logic                res_xfer;

    assign cmd_xfer = i_cmd.valid & i_cmd.ready;
    assign res_xfer = o_res.valid & o_res.ready;
    assign tick_sum = {1'b0, r_tick_cnt} + 1'b1;

    ttseq_store #(
        .DEPTH  (NOTE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_play_idx[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    ttseq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_timer_clock),
        .i_divisor  (mem_rdata.freq),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_clock <= CLOCK_RESET;
        end else if (i_cfg.valid) begin
            r_timer_clock <= i_cfg.timer_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_load_ptr     <= '0;
            r_tune_len     <= '0;
            r_play_idx     <= '0;
            r_tick_cnt     <= '0;
            r_tone_running <= 1'b0;
            r_period       <= '0;
            r_dropped      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_load_ptr     <= n_load_ptr;
            r_tune_len     <= n_tune_len;
            r_play_idx     <= n_play_idx;
            r_tick_cnt     <= n_tick_cnt;
            r_tone_running <= n_tone_running;
            r_period       <= n_period;
            r_dropped      <= n_dropped;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_load_ptr     = r_load_ptr;
        n_tune_len     = r_tune_len;
        n_play_idx     = r_play_idx;
        n_tick_cnt     = r_tick_cnt;
        n_tone_running = r_tone_running;
        n_period       = r_period;
        n_dropped      = r_dropped;
        mem_we         = 1'b0;
        mem_waddr      = r_load_ptr[ADDR_W-1:0];
        mem_wdata      = '{freq: pitch_freq(i_cmd.pitch_index), len: i_cmd.note_length};
        mem_re         = 1'b0;
        div_start      = 1'b0;
        i_cmd.ready    = 1'b0;
        o_res.valid    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (cmd_xfer) begin
                    n_dropped = 1'b0;
                    n_state   = ST_OUT;
                    case (i_cmd.command)
                        CMD_BEGIN: begin
                            n_load_ptr = '0;
                        end
                        CMD_APPEND: begin
                            if (r_load_ptr == PTR_W'(NOTE_DEPTH)) begin
                                n_dropped = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                n_load_ptr = r_load_ptr + 1'b1;
                            end
                        end
                        CMD_PLAY: begin
                            n_tune_len = r_load_ptr;
                            n_play_idx = '0;
                        end
                        CMD_TONE: begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = '{freq: i_cmd.frequency, len: i_cmd.note_length};
                            n_tune_len = PTR_W'(1);
                            n_play_idx = '0;
                        end
                        CMD_TICK: begin
                            if (r_play_idx < r_tune_len) begin
                                mem_re  = 1'b1;
                                n_state = ST_EVAL;
                            end else begin
                                n_tone_running = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                if (tick_sum >= {1'b0, mem_rdata.len}) begin
                    n_tick_cnt = '0;
                    n_play_idx = r_play_idx + 1'b1;
                end else begin
                    n_tick_cnt = tick_sum[LEN_W-1:0];
                end
                n_state = ST_OUT;
                if (r_tick_cnt == '0) begin
                    if (mem_rdata.freq == '0) begin
                        n_tone_running = 1'b0;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_period       = div_quot;
                    n_tone_running = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_OUT: begin
                o_res.valid = 1'b1;
                if (res_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.tone_on     = r_tone_running;
    assign o_res.tone_period = r_tone_running ? r_period : '0;
    assign o_res.playing     = (r_play_idx < r_tune_len);
    assign o_res.dropped     = r_dropped;

    a_play_in_tune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_play_idx <= r_tune_len)
        else $error("play index beyond tune length");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_ptr <= PTR_W'(NOTE_DEPTH))
        else $error("load pointer beyond store depth");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> r_state == ST_DIV)
        else $error("divider busy outside division state");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_cmd.ready)
        else $error("command accepted while result pending");

    a_div_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && div_stat.done) |=> r_state == ST_OUT && r_tone_running)
        else $error("division result not taken");

endmodule

`default_nettype wire

>>> bench/tone_tune_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the tone tune sequencer: directed and random command streams.
module tone_tune_sequencer_tb;
    import ttseq_pkg::*;

    localparam int NOTE_DEPTH   = 512;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_CAP   = 200;

    localparam logic [CMD_W-1:0]    CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0]    CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0]    CMD_SPARE_C = 3'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_SAT  = '1;

    typedef struct packed {
        logic                tone_on;
        logic [PERIOD_W-1:0] tone_period;
        logic                playing;
        logic                dropped;
    } t_status;

    logic clk;
    logic rst_n;

    ttseq_cmd_if cmd_if ();
    ttseq_res_if res_if ();
    ttseq_cfg_if cfg_if ();

    tone_tune_sequencer #(.NOTE_DEPTH(NOTE_DEPTH)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    logic [CLK_W-1:0]    mdl_clock;
    logic [FREQ_W-1:0]   note_freq [NOTE_DEPTH];
    logic [LEN_W-1:0]    note_len  [NOTE_DEPTH];
    int                  load_ptr;
    int                  tune_len;
    int                  play_idx;
    int                  tick_cnt;
    logic                tone_run;
    logic [PERIOD_W-1:0] period_hold;

    t_status status_due [$];
    int      mismatches;
    int      items_sent;
    int      quiet_cycles;
    logic    no_idle;

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int stall_draw();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic t_status tune_status(input logic [CMD_W-1:0]  c,
                                            input logic [PIDX_W-1:0] p,
                                            input logic [FREQ_W-1:0] f,
                                            input logic [LEN_W-1:0]  l);
        logic [FREQ_W-1:0] hz;
        logic [CLK_W-1:0]  quot;
        t_status           s;
        s.dropped = 1'b0;
        case (c)
            CMD_BEGIN: load_ptr = 0;
            CMD_APPEND: begin
                if (load_ptr >= NOTE_DEPTH) begin
                    s.dropped = 1'b1;
                end else begin
                    hz = '0;
                    if (p != '0 && p < PITCH_COUNT) begin
                        hz = FREQ_W'(PITCH_HZ[p]);
                    end
                    note_freq[load_ptr] = hz;
                    note_len[load_ptr]  = l;
                    load_ptr++;
                end
            end
            CMD_PLAY: begin
                tune_len = load_ptr;
                play_idx = 0;
            end
            CMD_TONE: begin
                note_freq[0] = f;
                note_len[0]  = l;
                tune_len     = 1;
                play_idx     = 0;
            end
            CMD_TICK: begin
                if (play_idx >= tune_len) begin
                    tone_run = 1'b0;
                end else begin
                    if (tick_cnt == 0) begin
                        hz = note_freq[play_idx];
                        if (hz == '0) begin
                            tone_run = 1'b0;
                        end else begin
                            quot        = mdl_clock / hz;
                            period_hold = (quot > PERIOD_SAT) ? PERIOD_SAT : quot[PERIOD_W-1:0];
                            tone_run    = 1'b1;
                        end
                    end
                    tick_cnt++;
                    if (tick_cnt >= note_len[play_idx]) begin
                        tick_cnt = 0;
                        play_idx++;
                    end
                end
            end
            default: ;
        endcase
        s.tone_on     = tone_run;
        s.tone_period = tone_run ? period_hold : '0;
        s.playing     = (play_idx < tune_len);
        return s;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_CAP) begin
            $display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
        end
        mismatches++;
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0]  c, input logic [PIDX_W-1:0] p,
                            input logic [FREQ_W-1:0] f, input logic [LEN_W-1:0]  l);
        int gap;
        gap = stall_draw();
        @(negedge clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= c;
        cmd_if.pitch_index <= p;
        cmd_if.frequency   <= f;
        cmd_if.note_length <= l;
        do @(posedge clk); while (!cmd_if.ready);
        status_due.push_back(tune_status(c, p, f, l));
        items_sent++;
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] c);
        send_cmd(c, PIDX_W'($urandom), FREQ_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic append_note(input logic [PIDX_W-1:0] p, input logic [LEN_W-1:0] l);
        send_cmd(CMD_APPEND, p, FREQ_W'($urandom), l);
    endtask

    task automatic single_tone(input logic [FREQ_W-1:0] f, input logic [LEN_W-1:0] l);
        send_cmd(CMD_TONE, PIDX_W'($urandom), f, l);
    endtask

    task automatic tick_tune(input int n);
        repeat (n) send_plain(CMD_TICK);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_timer_clock(input logic [CLK_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.timer_clock <= v;
        do @(posedge clk); while (!cfg_if.ready);
        mdl_clock = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_idle_status();
        tick_tune(1);
        send_plain(CMD_PLAY);
        tick_tune(1);
        send_plain(CMD_SPARE_A);
        send_plain(CMD_SPARE_B);
        send_plain(CMD_SPARE_C);
    endtask

    task automatic test_indexed_tune();
        send_plain(CMD_BEGIN);
        append_note(0, 1);
        append_note(1, 0);
        append_note(71, 2);
        append_note(72, 1);
        append_note(127, 0);
        append_note(36, 3);
        send_plain(CMD_PLAY);
        tick_tune(11);
        // restart mid-note: the tick count carries over
        send_plain(CMD_BEGIN);
        append_note(12, 4);
        append_note(24, 2);
        send_plain(CMD_PLAY);
        tick_tune(2);
        send_plain(CMD_PLAY);
        tick_tune(8);
    endtask

    task automatic test_timer_clock();
        logic [CLK_W-1:0]  rates [5];
        logic [FREQ_W-1:0] tones [3];
        rates = '{'0, CLK_W'(1), CLK_W'(16000000), '1, CLOCK_RESET};
        tones = '{FREQ_W'(1), FREQ_W'(3322), '1};
        single_tone('0, 2);
        tick_tune(3);
        foreach (rates[r]) begin
            write_timer_clock(rates[r]);
            foreach (tones[t]) begin
                single_tone(tones[t], 0);
                tick_tune(1);
            end
        end
    endtask

    task automatic test_store_full();
        no_idle = 1'b1;
        send_plain(CMD_BEGIN);
        repeat (NOTE_DEPTH) append_note(PIDX_W'($urandom_range(0, 127)),
                                        LEN_W'($urandom_range(0, 1)));
        append_note(36, 1);
        append_note(0, 0);
        no_idle = 1'b0;
        send_plain(CMD_PLAY);
        tick_tune(20);
        // reload while playing: the running tune stays
        send_plain(CMD_BEGIN);
        append_note(48, 1);
        tick_tune(4);
        drain_results();
    endtask

    task automatic test_random_tunes();
        int               first;
        int               ticks;
        int               len;
        int               kind;
        logic [CLK_W-1:0] rate;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 5))
                    0:       rate = '0;
                    1:       rate = CLK_W'(1);
                    2:       rate = CLK_W'(16000000);
                    3:       rate = '1;
                    4:       rate = CLOCK_RESET;
                    default: rate = CLK_W'($urandom);
                endcase
                write_timer_clock(rate);
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                ticks = 0;
                send_plain(CMD_BEGIN);
                repeat ($urandom_range(1, 8)) begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 3);
                    append_note(PIDX_W'($urandom_range(0, 127)), LEN_W'(len));
                    ticks += (len == 0) ? 1 : len;
                end
                send_plain(CMD_PLAY);
                tick_tune((ticks > 40) ? 40 : ticks + $urandom_range(0, 2));
            end else if (kind < 9) begin
                len = $urandom_range(0, 4);
                single_tone(FREQ_W'($urandom_range(0, 32767)), LEN_W'(len));
                tick_tune(len + $urandom_range(1, 2));
            end else begin
                repeat ($urandom_range(1, 6)) send_plain(CMD_W'($urandom));
            end
        end
    endtask

    initial begin : status_check
        t_status want;
        int      stall;
        res_if.ready = 1'b0;
        forever begin
            stall = stall_draw();
            @(negedge clk);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            if (status_due.size() == 0) begin
                report_mismatch("status with nothing pending", 0, 0);
            end else begin
                want = status_due.pop_front();
                if (res_if.tone_on !== want.tone_on)
                    report_mismatch("tone_on", 32'(res_if.tone_on), 32'(want.tone_on));
                if (res_if.tone_period !== want.tone_period)
                    report_mismatch("tone_period", 32'(res_if.tone_period),
                                    32'(want.tone_period));
                if (res_if.playing !== want.playing)
                    report_mismatch("playing", 32'(res_if.playing), 32'(want.playing));
                if (res_if.dropped !== want.dropped)
                    report_mismatch("dropped", 32'(res_if.dropped), 32'(want.dropped));
            end
        end
    end

    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_BEGIN;
        cmd_if.pitch_index = '0;
        cmd_if.frequency   = '0;
        cmd_if.note_length = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.timer_clock = '0;
        mismatches         = 0;
        items_sent         = 0;
        quiet_cycles       = 0;
        no_idle            = 1'b0;
        mdl_clock          = CLOCK_RESET;
        load_ptr           = 0;
        tune_len           = 0;
        play_idx           = 0;
        tick_cnt           = 0;
        tone_run           = 1'b0;
        period_hold        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_status();
        test_indexed_tune();
        test_timer_clock();
        test_store_full();
        test_random_tunes();

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ttseq_pkg.sv
rtl/ttseq_if.sv
rtl/ttseq_store.sv
rtl/ttseq_div.sv
rtl/tone_tune_sequencer.sv
bench/tone_tune_sequencer_tb.sv
